FILE: rtl/mini_aes_block_cipher_top_defines.svh
// Assertion macros for the mini AES block cipher.
// Used by rtl/mini_aes_block_cipher_top.sv; expects clk and rst_n in scope.
`ifndef MINI_AES_BLOCK_CIPHER_TOP_DEFINES_SVH
`define MINI_AES_BLOCK_CIPHER_TOP_DEFINES_SVH

`ifndef SYNTH
// Clocked check, disabled while reset is asserted
`define MAES_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define MAES_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MAES_ASSERT(lbl, prop, msg)
`define MAES_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: rtl/maes_pkg.sv
// Shared types, constants and GF(16) / S-box helpers for the mini AES cipher.
// No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps

package maes_pkg;

    typedef logic [3:0]  nibble_t;
    typedef logic [15:0] block_t;

    // Control that travels with each block down the pipeline
    typedef struct packed {
        logic valid;
        logic decrypt;
    } stage_ctrl_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CIPHER_KEY = 1'b0,
        REG_MIX_MATRIX = 1'b1
    } cfg_reg_t;

    // Request codes
    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    localparam block_t  CIPHER_KEY_RESET = 16'h0000;
    localparam block_t  MIX_MATRIX_RESET = 16'h3223;
    localparam logic [4:0] GF_POLY = 5'b10011;
    localparam nibble_t RCON_1  = 4'b0001;
    localparam nibble_t RCON_2  = 4'b0010;

    localparam nibble_t SBOX_ENC [16] = '{
        4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
        4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
    };
    localparam nibble_t SBOX_DEC [16] = '{
        4'hE, 4'h3, 4'h4, 4'h8, 4'h1, 4'hC, 4'hA, 4'hF,
        4'h7, 4'hD, 4'h9, 4'h6, 4'hB, 4'h2, 4'h0, 4'h5
    };

    // Nibble i of a block, nibble 0 in the top bits
    function automatic nibble_t nib(input block_t v, input logic [1:0] i);
        nibble_t r;
        r = v[15 - 4 * i -: 4];
        return r;
    endfunction

    // Substitute all four nibbles, forward or inverse box
    function automatic block_t sub_block(input block_t v, input logic inv);
        block_t r;
        for (int i = 0; i < 4; i++)
        begin
            r[15 - 4 * i -: 4] = inv ? SBOX_DEC[nib(v, 2'(i))] : SBOX_ENC[nib(v, 2'(i))];
        end
        return r;
    endfunction

    // Swap nibbles 2 and 3
    function automatic block_t swap_low(input block_t v);
        return {v[15:8], v[3:0], v[7:4]};
    endfunction

    // GF(16) multiply modulo x^4+x+1
    function automatic nibble_t gf_mul(input nibble_t a, input nibble_t b);
        logic [6:0] acc;
        acc = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ ({3'b000, a} << i);
            end
        end
        for (int i = 6; i >= 4; i--)
        begin
            if (acc[i])
            begin
                acc = acc ^ ({2'b00, GF_POLY} << (i - 4));
            end
        end
        return acc[3:0];
    endfunction

    // Column mix with a 2x2 coefficient matrix, row-major in m
    function automatic block_t mix_block(input block_t v, input block_t m);
        nibble_t m0, m1, m2, m3, n0, n1, n2, n3;
        m0 = m[15:12]; m1 = m[11:8]; m2 = m[7:4]; m3 = m[3:0];
        n0 = v[15:12]; n1 = v[11:8]; n2 = v[7:4]; n3 = v[3:0];
        return {gf_mul(m0, n0) ^ gf_mul(m1, n2),
                gf_mul(m0, n1) ^ gf_mul(m1, n3),
                gf_mul(m2, n0) ^ gf_mul(m3, n2),
                gf_mul(m2, n1) ^ gf_mul(m3, n3)};
    endfunction

    // One step of the key schedule
    function automatic block_t next_key(input block_t w, input nibble_t rc);
        nibble_t v0, v1, v2, v3;
        v0 = w[15:12] ^ SBOX_ENC[w[3:0]] ^ rc;
        v2 = w[7:4] ^ v0;
        v1 = w[11:8] ^ v2;
        v3 = w[3:0] ^ v1;
        return {v0, v1, v2, v3};
    endfunction

endpackage

FILE: rtl/mini_aes_block_cipher_top.sv
// Top level of the two-round mini AES cipher: config registers and 3-stage pipeline.
// Depends on maes_pkg, maes_key_sched, maes_sub_stage, maes_mix_stage and the defines header.
//
//  channel   handshake            payload
//  -------   -------------------  ----------------------------
//  request   start, busy          req_type, block_in
//  result    done (strobe)        block_out
//  config    cfg_wr_en            cfg_index, cfg_data
//
// One block enters per cycle; busy stays low, so every start is a transaction.
// A block passes through an S-box stage, a mix stage and an S-box stage, each registered.
// done is high for the one cycle that block_out is valid; no backpressure.
// Reset (async, active low) clears stage valids and loads the key and matrix defaults.
`timescale 1ns / 1ps

`include "mini_aes_block_cipher_top_defines.svh"

module mini_aes_block_cipher_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic [15:0]                       block_in,
    output logic                              done,
    output logic [15:0]                       block_out,
    input  logic                              cfg_wr_en,
    input  logic [maes_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data
);

    maes_pkg::block_t      cipher_key_reg;
    maes_pkg::block_t      mix_matrix_reg;
    maes_pkg::block_t      round_key1;
    maes_pkg::block_t      round_key2;
    maes_pkg::stage_ctrl_t s0_ctrl;
    maes_pkg::stage_ctrl_t s1_ctrl;
    maes_pkg::stage_ctrl_t s2_ctrl;
    maes_pkg::stage_ctrl_t s3_ctrl;
    maes_pkg::block_t      s1_data;
    maes_pkg::block_t      s2_data;
    maes_pkg::block_t      s3_data;
    maes_pkg::block_t      s1_pre_key;
    maes_pkg::block_t      s3_post_key;
    logic                  accept;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg <= maes_pkg::CIPHER_KEY_RESET;
            mix_matrix_reg <= maes_pkg::MIX_MATRIX_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (maes_pkg::cfg_reg_t'(cfg_index))
                maes_pkg::REG_CIPHER_KEY: cipher_key_reg <= cfg_data;
                maes_pkg::REG_MIX_MATRIX: mix_matrix_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    maes_key_sched u_key_sched (
        .cipher_key (cipher_key_reg),
        .round_key1 (round_key1),
        .round_key2 (round_key2)
    );

    // Request transaction
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign s0_ctrl.valid   = accept;
    assign s0_ctrl.decrypt = (req_type == maes_pkg::REQ_DECRYPT);

    // Outer key selection: whitening key and k2 swap ends for decryption
    assign s1_pre_key  = s0_ctrl.decrypt ? round_key2 : cipher_key_reg;
    assign s3_post_key = s2_ctrl.decrypt ? cipher_key_reg : round_key2;

    maes_sub_stage u_stage1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (s0_ctrl),
        .data_in  (block_in),
        .pre_key  (s1_pre_key),
        .post_key ('0),
        .ctrl_out (s1_ctrl),
        .data_out (s1_data)
    );

    maes_mix_stage u_stage2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_in   (s1_ctrl),
        .data_in   (s1_data),
        .round_key (round_key1),
        .mix_coef  (mix_matrix_reg),
        .ctrl_out  (s2_ctrl),
        .data_out  (s2_data)
    );

    maes_sub_stage u_stage3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (s2_ctrl),
        .data_in  (s2_data),
        .pre_key  ('0),
        .post_key (s3_post_key),
        .ctrl_out (s3_ctrl),
        .data_out (s3_data)
    );

    assign done      = s3_ctrl.valid;
    assign block_out = s3_data;

    // Every accepted block comes out at done, and nothing else does
    `MAES_ASSERT(a_accept_to_done, accept |-> ##3 done, "accepted block did not complete")
    `MAES_ASSERT(a_done_from_accept, done |-> $past(accept, 3), "result without a request")
    `MAES_ASSERT(a_mode_kept, done |-> (s3_ctrl.decrypt == $past(s0_ctrl.decrypt, 3)),
                 "mode lost in pipeline")

endmodule

FILE: rtl/maes_key_sched.sv
// Round key derivation for the mini AES cipher: k1 and k2 from the whitening key.
// Depends on maes_pkg.
`timescale 1ns / 1ps

module maes_key_sched (
    input  maes_pkg::block_t cipher_key,
    output maes_pkg::block_t round_key1,
    output maes_pkg::block_t round_key2
);

    // Two chained schedule steps with round constants 1 and 2
    assign round_key1 = maes_pkg::next_key(cipher_key, maes_pkg::RCON_1);
    assign round_key2 = maes_pkg::next_key(round_key1, maes_pkg::RCON_2);

endmodule

FILE: rtl/maes_sub_stage.sv
// Pipeline stage: key add, nibble swap and S-box layer, forward or inverse.
// Depends on maes_pkg.
`timescale 1ns / 1ps

module maes_sub_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  maes_pkg::stage_ctrl_t  ctrl_in,
    input  maes_pkg::block_t       data_in,
    input  maes_pkg::block_t       pre_key,
    input  maes_pkg::block_t       post_key,
    output maes_pkg::stage_ctrl_t  ctrl_out,
    output maes_pkg::block_t       data_out
);

    maes_pkg::stage_ctrl_t ctrl_reg;
    maes_pkg::block_t      data_reg;
    maes_pkg::block_t      data_next;
    maes_pkg::block_t      keyed;

    // Encrypt: swap after S-box; decrypt: swap before inverse S-box
    always_comb
    begin
        keyed = data_in ^ pre_key;
        if (ctrl_in.decrypt)
        begin
            data_next = maes_pkg::sub_block(maes_pkg::swap_low(keyed), 1'b1) ^ post_key;
        end
        else
        begin
            data_next = maes_pkg::swap_low(maes_pkg::sub_block(keyed, 1'b0)) ^ post_key;
        end
    end

    // Valid and mode carry reset; data does not
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign ctrl_out = ctrl_reg;
    assign data_out = data_reg;

endmodule

FILE: rtl/maes_mix_stage.sv
// Pipeline stage: GF(16) column mix with round key 1 before or after it.
// Depends on maes_pkg.
`timescale 1ns / 1ps

module maes_mix_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  maes_pkg::stage_ctrl_t  ctrl_in,
    input  maes_pkg::block_t       data_in,
    input  maes_pkg::block_t       round_key,
    input  maes_pkg::block_t       mix_coef,
    output maes_pkg::stage_ctrl_t  ctrl_out,
    output maes_pkg::block_t       data_out
);

    maes_pkg::stage_ctrl_t ctrl_reg;
    maes_pkg::block_t      data_reg;
    maes_pkg::block_t      data_next;

    // Encrypt: mix then add key; decrypt: add key then mix
    always_comb
    begin
        if (ctrl_in.decrypt)
        begin
            data_next = maes_pkg::mix_block(data_in ^ round_key, mix_coef);
        end
        else
        begin
            data_next = maes_pkg::mix_block(data_in, mix_coef) ^ round_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign ctrl_out = ctrl_reg;
    assign data_out = data_reg;

endmodule
